// ===== rtl/core/trz_pkg.sv =====
// Shared types, sizes and state codes of the triangle rasterizer.
package trz_pkg;

	// image size in pixels
	localparam int IMG_WIDTH  = 512;
	localparam int IMG_HEIGHT = 512;

	localparam int COL_W    = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
	localparam int ROW_W    = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
	localparam int FB_DEPTH = IMG_WIDTH * IMG_HEIGHT;
	localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

	// 12.4 vertex coordinates and the edge arithmetic built on them
	localparam int COORD_W = 16;
	localparam int FRAC_W  = 4;
	localparam int PIX_W   = COORD_W + 1;         // pixel centre in 12.4, always >= 0
	localparam int DIFF_W  = COORD_W + 2;         // vertex minus pixel
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int EDGE_W  = PROD_W + 2;          // edge function value
	localparam int STEP_W  = COORD_W + 1 + FRAC_W; // edge increment per pixel step

	// added before the shift to round a 12.4 value up to a whole pixel
	localparam logic signed [COORD_W:0] CEIL_BIAS = (COORD_W+1)'((1 << FRAC_W) - 1);

	localparam int COLOR_W = 32;
	localparam int RD_W    = 9;

	// setup products: two per edge
	localparam int N_MUL  = 6;
	localparam int MSEL_W = 3;
	localparam logic [MSEL_W-1:0] MSEL_LAST = MSEL_W'(N_MUL - 1);

	typedef logic signed [COORD_W-1:0] trz_coord_t;

	typedef struct packed {
		trz_coord_t x0;
		trz_coord_t y0;
		trz_coord_t x1;
		trz_coord_t y1;
		trz_coord_t x2;
		trz_coord_t y2;
	} trz_tri_t;

	// sequencer to edge unit
	typedef struct packed {
		logic              mul_en;
		logic [MSEL_W-1:0] mul_sel;
		logic              step_y;
		logic              step_x;
	} trz_edge_ctl_t;

	typedef enum logic {
		OP_DRAW = 1'b0,
		OP_READ = 1'b1
	} trz_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BOX,
		ST_MUL,
		ST_DRAIN,
		ST_AREA,
		ST_SCAN,
		ST_READ,
		ST_RESP
	} trz_state_t;

endpackage

// ===== rtl/core/trz_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module trz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/trz_edge_unit.sv =====
// Edge function unit: one shared multiplier for setup, then incremental stepping.
module trz_edge_unit import trz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  trz_edge_ctl_t    ctl,
	input  trz_tri_t         triangle,
	input  logic [COL_W-1:0] org_x,
	input  logic [ROW_W-1:0] org_y,
	output logic             covered,
	output logic             area_neg
);

	trz_coord_t               vx [3];
	trz_coord_t               vy [3];
	logic signed [PIX_W-1:0]  px;
	logic signed [PIX_W-1:0]  py;
	logic signed [DIFF_W-1:0] ox [3];
	logic signed [DIFF_W-1:0] oy [3];
	logic signed [COORD_W:0]  dvx [3];
	logic signed [COORD_W:0]  dvy [3];
	logic signed [STEP_W-1:0] dx_step [3];
	logic signed [STEP_W-1:0] dy_step [3];
	logic signed [DIFF_W-1:0] opa_tab [N_MUL];
	logic signed [DIFF_W-1:0] opb_tab [N_MUL];
	logic signed [DIFF_W-1:0] op_a;
	logic signed [DIFF_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic [MSEL_W-1:0]        sel_s1;
	logic                     vld_s1;
	logic signed [EDGE_W-1:0] e_q [3];
	logic signed [EDGE_W-1:0] col_q [3];
	logic signed [EDGE_W-1:0] area_sum;

	assign vx[0] = triangle.x0;
	assign vy[0] = triangle.y0;
	assign vx[1] = triangle.x1;
	assign vy[1] = triangle.y1;
	assign vx[2] = triangle.x2;
	assign vy[2] = triangle.y2;

	// scan origin in 12.4
	assign px = PIX_W'({org_x, {FRAC_W{1'b0}}});
	assign py = PIX_W'({org_y, {FRAC_W{1'b0}}});

	// vertex offsets from the origin and per-edge step increments
	for (genvar i = 0; i < 3; i++) begin : g_vtx
		localparam int BI = (i + 1) % 3;
		localparam int CI = (i + 2) % 3;
		assign ox[i]      = DIFF_W'(vx[i]) - DIFF_W'(px);
		assign oy[i]      = DIFF_W'(vy[i]) - DIFF_W'(py);
		assign dvy[i]     = (COORD_W+1)'(vy[BI]) - (COORD_W+1)'(vy[CI]);
		assign dvx[i]     = (COORD_W+1)'(vx[CI]) - (COORD_W+1)'(vx[BI]);
		assign dx_step[i] = STEP_W'(dvy[i]) <<< FRAC_W;
		assign dy_step[i] = STEP_W'(dvx[i]) <<< FRAC_W;
	end

	// operand pairs: even step (bx-px)*(cy-py), odd step (by-py)*(cx-px)
	for (genvar s = 0; s < N_MUL; s++) begin : g_ops
		localparam int EI = s / 2;
		localparam int BI = (EI + 1) % 3;
		localparam int CI = (EI + 2) % 3;
		if ((s % 2) == 0) begin : g_even
			assign opa_tab[s] = ox[BI];
			assign opb_tab[s] = oy[CI];
		end else begin : g_odd
			assign opa_tab[s] = oy[BI];
			assign opb_tab[s] = ox[CI];
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (ctl.mul_sel <= MSEL_LAST) begin
			op_a = opa_tab[ctl.mul_sel];
			op_b = opb_tab[ctl.mul_sel];
		end
	end

	// shared multiplier, product registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= op_a * op_b;
			sel_s1  <= ctl.mul_sel;
		end
	end

	// edge accumulators: load from the products, then step across the box
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (vld_s1 && (sel_s1[MSEL_W-1:1] == (MSEL_W-1)'(i))) begin
				if (!sel_s1[0]) begin
					e_q[i] <= EDGE_W'(prod_s1);
				end else begin
					e_q[i]   <= e_q[i] - EDGE_W'(prod_s1);
					col_q[i] <= e_q[i] - EDGE_W'(prod_s1);
				end
			end else if (ctl.step_x) begin
				col_q[i] <= col_q[i] + EDGE_W'(dx_step[i]);
				e_q[i]   <= col_q[i] + EDGE_W'(dx_step[i]);
			end else if (ctl.step_y) begin
				e_q[i] <= e_q[i] + EDGE_W'(dy_step[i]);
			end
		end
	end

	// once all products are in, the edge values sum to the signed area
	assign area_sum = e_q[0] + e_q[1] + e_q[2];
	assign area_neg = area_sum[EDGE_W-1];
	assign covered  = !e_q[0][EDGE_W-1] && !e_q[1][EDGE_W-1] && !e_q[2][EDGE_W-1];

endmodule

// ===== rtl/core/triangle_rasterizer_unit.sv =====
// Triangle rasterizer top level: sequencer, bounding box, framebuffer and result register.
// After reset the framebuffer is swept to zero, one pixel a cycle; no item is taken
// meanwhile. A draw item first runs its setup (bounding box, passes through the one
// shared 18 x 18 multiplier to form the edge functions, area check) and then scans
// its clamped bounding box one pixel a cycle, set by the single framebuffer write port.
// A culled triangle finishes after the setup. The next item is taken once the result has
// moved to the output register, and one result is given for every item.
module triangle_rasterizer_unit import trz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               operation,
	input  trz_coord_t         vertex0_x,
	input  trz_coord_t         vertex0_y,
	input  trz_coord_t         vertex1_x,
	input  trz_coord_t         vertex1_y,
	input  trz_coord_t         vertex2_x,
	input  trz_coord_t         vertex2_y,
	input  logic [COLOR_W-1:0] fill_color,
	input  logic [RD_W-1:0]    read_column,
	input  logic [RD_W-1:0]    read_row,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               triangle_culled
);

	trz_state_t         state_q;
	trz_state_t         state_d;
	trz_op_t            op_q;
	trz_tri_t           tri_q;
	logic [COLOR_W-1:0] color_q;
	logic [FB_AW-1:0]   rd_addr_q;
	logic               rd_hit_q;
	logic               cull_q;
	logic [COL_W-1:0]   minx_q;
	logic [COL_W-1:0]   maxx_q;
	logic [ROW_W-1:0]   miny_q;
	logic [ROW_W-1:0]   maxy_q;
	logic [COL_W-1:0]   x_q;
	logic [ROW_W-1:0]   y_q;
	logic [FB_AW-1:0]   clr_addr_q;
	logic [MSEL_W-1:0]  mul_sel_q;
	logic               rsp_valid_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               culled_q;

	logic               req_acc;
	logic               rsp_free;
	logic               last_x;
	logic               last_y;
	logic               last_clr;
	logic [FB_AW-1:0]   scan_addr;
	trz_edge_ctl_t      ctl;
	logic               covered;
	logic               area_neg;
	logic               ram_we;
	logic [FB_AW-1:0]   ram_waddr;
	logic [COLOR_W-1:0] ram_wdata;
	logic               ram_re;
	logic [COLOR_W-1:0] ram_rdata;

	function automatic trz_coord_t min3(input trz_coord_t a, input trz_coord_t b,
		input trz_coord_t c);
		trz_coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic trz_coord_t max3(input trz_coord_t a, input trz_coord_t b,
		input trz_coord_t c);
		trz_coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic signed [COORD_W:0] floor_px(input trz_coord_t v);
		logic signed [COORD_W:0] t;
		t = (COORD_W+1)'(v);
		return t >>> FRAC_W;
	endfunction

	function automatic logic signed [COORD_W:0] ceil_px(input trz_coord_t v);
		logic signed [COORD_W:0] t;
		t = (COORD_W+1)'(v);
		t = t + CEIL_BIAS;
		return t >>> FRAC_W;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_idx(input logic signed [COORD_W:0] v,
		input int hi);
		logic [COORD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = COORD_W'(hi);
		end else begin
			r = COORD_W'(v);
		end
		return r;
	endfunction

	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign last_x    = (x_q == maxx_q);
	assign last_y    = (y_q == maxy_q);
	assign last_clr  = (clr_addr_q == FB_AW'(FB_DEPTH - 1));
	assign scan_addr = FB_AW'(y_q) * FB_AW'(IMG_WIDTH) + FB_AW'(x_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (last_clr) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (trz_op_t'(operation) == OP_READ) ? ST_READ : ST_BOX;
				end
			end
			ST_BOX:   state_d = ST_MUL;
			ST_MUL: begin
				if (mul_sel_q == MSEL_LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_AREA;
			ST_AREA:  state_d = area_neg ? ST_RESP : ST_SCAN;
			ST_SCAN: begin
				if (last_x && last_y) state_d = ST_RESP;
			end
			ST_READ:  state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		ctl       = '0;
		ram_we    = 1'b0;
		ram_waddr = scan_addr;
		ram_wdata = color_q;
		ram_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_MUL: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = mul_sel_q;
			end
			ST_SCAN: begin
				ram_we     = covered;
				ctl.step_y = !last_y;
				ctl.step_x = last_y && !last_x;
			end
			ST_READ: begin
				ram_re = rd_hit_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			mul_sel_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_MUL) begin
				mul_sel_q <= mul_sel_q + 1'b1;
			end else begin
				mul_sel_q <= '0;
			end
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item capture, bounding box and scan position
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q      <= trz_op_t'(operation);
			tri_q.x0  <= vertex0_x;
			tri_q.y0  <= vertex0_y;
			tri_q.x1  <= vertex1_x;
			tri_q.y1  <= vertex1_y;
			tri_q.x2  <= vertex2_x;
			tri_q.y2  <= vertex2_y;
			color_q   <= fill_color;
			cull_q    <= 1'b0;
			rd_hit_q  <= (int'(read_column) < IMG_WIDTH) && (int'(read_row) < IMG_HEIGHT);
			rd_addr_q <= FB_AW'(read_row) * FB_AW'(IMG_WIDTH) + FB_AW'(read_column);
		end
		if (state_q == ST_BOX) begin
			minx_q <= COL_W'(clamp_idx(floor_px(min3(tri_q.x0, tri_q.x1, tri_q.x2)),
				IMG_WIDTH - 1));
			maxx_q <= COL_W'(clamp_idx(ceil_px(max3(tri_q.x0, tri_q.x1, tri_q.x2)),
				IMG_WIDTH - 1));
			miny_q <= ROW_W'(clamp_idx(floor_px(min3(tri_q.y0, tri_q.y1, tri_q.y2)),
				IMG_HEIGHT - 1));
			maxy_q <= ROW_W'(clamp_idx(ceil_px(max3(tri_q.y0, tri_q.y1, tri_q.y2)),
				IMG_HEIGHT - 1));
		end
		if (state_q == ST_AREA) begin
			cull_q <= area_neg;
			x_q    <= minx_q;
			y_q    <= miny_q;
		end
		if (ctl.step_y) begin
			y_q <= y_q + 1'b1;
		end
		if (ctl.step_x) begin
			x_q <= x_q + 1'b1;
			y_q <= miny_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && rsp_free) begin
			pixel_color_q <= (op_q == OP_READ && rd_hit_q) ? ram_rdata : '0;
			culled_q      <= cull_q;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign pixel_color     = pixel_color_q;
	assign triangle_culled = culled_q;

	trz_edge_unit u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.triangle (tri_q),
		.org_x    (minx_q),
		.org_y    (miny_q),
		.covered  (covered),
		.area_neg (area_neg)
	);

	trz_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (FB_DEPTH)
	) u_fb (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// no result can be pending during the clearing sweep
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !rsp_valid_q)
		else $error("result pending during framebuffer clear");

	// the framebuffer is written only by the sweep or the scan
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_SCAN))
		else $error("framebuffer write outside clear or scan");

	// the scan stays within the clamped box
	a_scan_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (x_q >= minx_q && x_q <= maxx_q &&
		y_q >= miny_q && y_q <= maxy_q))
		else $error("scan position outside bounding box");

	// a negative area goes straight to the result with the cull flag
	a_cull: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AREA && area_neg) |=> (state_q == ST_RESP && cull_q))
		else $error("negative area triangle not culled");

endmodule

// ===== tb/trz_raster_checker.sv =====
// Raster checker: watches both channels, keeps a framebuffer copy and compares every result.
`timescale 1ns / 100ps
module trz_raster_checker import trz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic               operation,
	input  trz_coord_t         vertex0_x,
	input  trz_coord_t         vertex0_y,
	input  trz_coord_t         vertex1_x,
	input  trz_coord_t         vertex1_y,
	input  trz_coord_t         vertex2_x,
	input  trz_coord_t         vertex2_y,
	input  logic [COLOR_W-1:0] fill_color,
	input  logic [RD_W-1:0]    read_column,
	input  logic [RD_W-1:0]    read_row,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [COLOR_W-1:0] pixel_color,
	input  logic               triangle_culled,
	output int                 fail_count,
	output int                 owed_count
);

	typedef struct packed {
		logic [COLOR_W-1:0] colour;
		logic               culled;
	} pixel_reply_t;

	// shadow framebuffer, zero after reset like the real one
	bit [COLOR_W-1:0] frame_mem [FB_DEPTH];
	pixel_reply_t     replies_owed [$];

	initial begin
		fail_count = 0;
		owed_count = 0;
	end

	// 12.4 to whole pixels, rounding down or up
	function automatic int floor_px(int v);
		return v >>> FRAC_W;
	endfunction

	function automatic int ceil_px(int v);
		return -((-v) >>> FRAC_W);
	endfunction

	function automatic int fit_px(int v, int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	function automatic int min3(int a, int b, int c);
		int m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic int max3(int a, int b, int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// Draws one triangle into the shadow framebuffer; returns 1 when it is culled.
	function automatic logic rasterise_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
			logic [COLOR_W-1:0] colour);
		int     lo_x, hi_x, lo_y, hi_y, x, y;
		longint px, py, e12, e20, e01;
		// negative signed area: back facing, nothing written
		if (longint'(x1 - x0) * longint'(y2 - y0) - longint'(y1 - y0) * longint'(x2 - x0) < 0)
			return 1'b1;
		lo_x = fit_px(floor_px(min3(x0, x1, x2)), IMG_WIDTH - 1);
		hi_x = fit_px(ceil_px(max3(x0, x1, x2)), IMG_WIDTH - 1);
		lo_y = fit_px(floor_px(min3(y0, y1, y2)), IMG_HEIGHT - 1);
		hi_y = fit_px(ceil_px(max3(y0, y1, y2)), IMG_HEIGHT - 1);
		// x outer, y inner; a pixel is covered when every edge product is >= 0
		for (x = lo_x; x <= hi_x; x++) begin
			for (y = lo_y; y <= hi_y; y++) begin
				px  = longint'(x) * (1 << FRAC_W);
				py  = longint'(y) * (1 << FRAC_W);
				e12 = (x1 - px) * (y2 - py) - (y1 - py) * (x2 - px);
				e20 = (x2 - px) * (y0 - py) - (y2 - py) * (x0 - px);
				e01 = (x0 - px) * (y1 - py) - (y0 - py) * (x1 - px);
				if (e12 >= 0 && e20 >= 0 && e01 >= 0)
					frame_mem[x + y * IMG_WIDTH] = colour;
			end
		end
		return 1'b0;
	endfunction

	// results are checked before the same edge's item is predicted
	always @(posedge clk) begin : watch
		pixel_reply_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (replies_owed.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with none owed: colour %h culled %b",
							$time, pixel_color, triangle_culled);
					fail_count++;
				end else begin
					want = replies_owed.pop_front();
					if (pixel_color !== want.colour || triangle_culled !== want.culled) begin
						if (fail_count < 10)
							$display({"%0t: mismatch: expected colour %h culled %b, ",
								"got colour %h culled %b"},
								$time, want.colour, want.culled, pixel_color, triangle_culled);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (operation == OP_READ) begin
					want.culled = 1'b0;
					want.colour = (read_column < IMG_WIDTH && read_row < IMG_HEIGHT) ?
						frame_mem[read_column + read_row * IMG_WIDTH] : '0;
				end else begin
					want.colour = '0;
					want.culled = rasterise_triangle(int'(vertex0_x), int'(vertex0_y),
						int'(vertex1_x), int'(vertex1_y), int'(vertex2_x), int'(vertex2_y),
						fill_color);
				end
				replies_owed = {replies_owed, want};
			end
			owed_count <= replies_owed.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, draw and read stimulus, result stalls and the verdict.
`timescale 1ns / 100ps
module tb_top;
	import trz_pkg::*;

	logic               clk;
	logic               arst_n          = 1'b0;
	logic               req_valid       = 1'b0;
	logic               req_stall;
	logic               operation       = OP_DRAW;
	trz_coord_t         vertex0_x       = '0;
	trz_coord_t         vertex0_y       = '0;
	trz_coord_t         vertex1_x       = '0;
	trz_coord_t         vertex1_y       = '0;
	trz_coord_t         vertex2_x       = '0;
	trz_coord_t         vertex2_y       = '0;
	logic [COLOR_W-1:0] fill_color      = '0;
	logic [RD_W-1:0]    read_column     = '0;
	logic [RD_W-1:0]    read_row        = '0;
	logic               rsp_valid;
	logic               rsp_stall       = 1'b0;
	logic [COLOR_W-1:0] pixel_color;
	logic               triangle_culled;

	int   fail_count;
	int   owed_count;
	logic calm    = 1'b0;   // last stretch: no gaps, no stalls
	int   gap_pct = 25;
	// where the last draw landed, so reads can find written pixels
	int   recent_x     = 0;
	int   recent_y     = 0;
	int   recent_reach = 16;

	triangle_rasterizer_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.operation       (operation),
		.vertex0_x       (vertex0_x),
		.vertex0_y       (vertex0_y),
		.vertex1_x       (vertex1_x),
		.vertex1_y       (vertex1_y),
		.vertex2_x       (vertex2_x),
		.vertex2_y       (vertex2_y),
		.fill_color      (fill_color),
		.read_column     (read_column),
		.read_row        (read_row),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.pixel_color     (pixel_color),
		.triangle_culled (triangle_culled)
	);

	trz_raster_checker u_raster_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.operation       (operation),
		.vertex0_x       (vertex0_x),
		.vertex0_y       (vertex0_y),
		.vertex1_x       (vertex1_x),
		.vertex1_y       (vertex1_y),
		.vertex2_x       (vertex2_x),
		.vertex2_y       (vertex2_y),
		.fill_color      (fill_color),
		.read_column     (read_column),
		.read_row        (read_row),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.pixel_color     (pixel_color),
		.triangle_culled (triangle_culled),
		.fail_count      (fail_count),
		.owed_count      (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hang guard: far beyond the clear pass plus the slowest plausible run
	initial begin
		#100_000_000;
		$display("triangle_rasterizer_unit test failed");
		$finish;
	end

	// result-side stalls in bursts, rate changing now and then
	initial begin : stall_gen
		int burst;
		int rate;
		burst = 0;
		rate  = 10;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) begin
				case ($urandom_range(0, 2))
					0: rate = 0;
					1: rate = 10;
					default: rate = 35;
				endcase
			end
			if (calm) begin
				burst = 0;
				rsp_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
			end else if ($urandom_range(0, 99) < rate) begin
				burst = $urandom_range(1, 6) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic int to_pixel(int v);
		int p;
		p = v >>> FRAC_W;
		return (p < 0) ? 0 : ((p > IMG_WIDTH - 1) ? IMG_WIDTH - 1 : p);
	endfunction

	// Presents one item, after an optional gap, and returns at the edge it is taken.
	task automatic send_item(trz_op_t op, int ax, int ay, int bx, int by, int cx, int cy,
			logic [COLOR_W-1:0] colour, int col, int row);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 6);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		operation   <= op;
		vertex0_x   <= COORD_W'(ax);
		vertex0_y   <= COORD_W'(ay);
		vertex1_x   <= COORD_W'(bx);
		vertex1_y   <= COORD_W'(by);
		vertex2_x   <= COORD_W'(cx);
		vertex2_y   <= COORD_W'(cy);
		fill_color  <= colour;
		read_column <= RD_W'(col);
		read_row    <= RD_W'(row);
		do @(posedge clk); while (req_stall);
	endtask

	// read fields are don't-care on a draw, so they carry noise
	task automatic send_draw(int ax, int ay, int bx, int by, int cx, int cy,
			logic [COLOR_W-1:0] colour);
		send_item(OP_DRAW, ax, ay, bx, by, cx, cy, colour,
			$urandom_range(0, 511), $urandom_range(0, 511));
	endtask

	// likewise vertices and colour on a read
	task automatic send_read(int col, int row);
		send_item(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, col, row);
	endtask

	// sender stays quiet until every owed result is back
	task automatic hold_until_empty();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0) @(posedge clk);
	endtask

	// Random draw: mostly small triangles on the image, some far off it, some
	// degenerate, and some full-range noise that is forced back facing.
	task automatic random_draw();
		int     kind, span, base_x, base_y, dx, dy, m1, m2, k, t;
		int     v [6];
		longint area;
		kind = $urandom_range(0, 99);
		span = ($urandom_range(0, 49) == 0) ? 768 : $urandom_range(8, 256);
		if (kind < 85) begin
			if (kind < 70) begin
				base_x = $urandom_range(0, 8300) - 64;
				base_y = $urandom_range(0, 8300) - 64;
			end else begin
				base_x = int'($urandom_range(0, 65535 - span)) - 32768;
				base_y = int'($urandom_range(0, 65535 - span)) - 32768;
			end
			for (k = 0; k < 6; k += 2) begin
				v[k]     = base_x + $urandom_range(0, span);
				v[k + 1] = base_y + $urandom_range(0, span);
			end
		end else if (kind < 95) begin
			// all three on one line, or stacked on one point
			base_x = $urandom_range(0, 8000);
			base_y = $urandom_range(0, 8000);
			dx     = int'($urandom_range(0, 256)) - 128;
			dy     = int'($urandom_range(0, 256)) - 128;
			m1     = $urandom_range(0, 2);
			m2     = $urandom_range(0, 2);
			v[0]   = base_x;
			v[1]   = base_y;
			v[2]   = base_x + m1 * dx;
			v[3]   = base_y + m1 * dy;
			v[4]   = base_x + m2 * dx;
			v[5]   = base_y + m2 * dy;
		end else begin
			base_x = 0;
			base_y = 0;
			for (k = 0; k < 6; k++)
				v[k] = int'($urandom_range(0, 65535)) - 32768;
		end
		area = longint'(v[2] - v[0]) * (v[5] - v[1]) - longint'(v[3] - v[1]) * (v[4] - v[0]);
		// swapping two vertices flips the winding
		if ((kind >= 95 && area > 0) || (kind < 85 && area < 0 && $urandom_range(0, 3) != 0)) begin
			t = v[2]; v[2] = v[4]; v[4] = t;
			t = v[3]; v[3] = v[5]; v[5] = t;
		end
		if (kind < 95) begin
			recent_x     = to_pixel(base_x);
			recent_y     = to_pixel(base_y);
			recent_reach = span / 16 + 2;
		end
		send_draw(v[0], v[1], v[2], v[3], v[4], v[5], $urandom);
	endtask

	initial begin : stimulus
		int i, col, row;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: cleared corners, a basic triangle, back facing, zero area
		send_read(0, 0);
		send_read(IMG_WIDTH - 1, IMG_HEIGHT - 1);
		send_draw(0, 0, 160, 0, 0, 160, 32'h11223344);
		send_read(2, 2);
		send_read(10, 10);
		send_draw(0, 0, 0, 160, 160, 0, 32'hDEADBEEF);
		send_read(3, 3);
		send_draw(320, 320, 480, 480, 640, 640, 32'h00FF00FF);
		send_read(25, 25);
		send_draw(704, 704, 704, 704, 704, 704, 32'hFF000000);
		send_read(44, 44);
		// fractional vertices
		send_draw(803, 611, 1101, 629, 917, 905, 32'h0000FF00);
		send_read(57, 45);
		// boxes clamped at the left, top, right and bottom borders
		send_draw(-20000, 1600, -19000, 1600, -20000, 2600, 32'h5A5AA5A5);
		send_draw(-80, -80, 400, -80, -80, 400, 32'hA5A55A5A);
		send_read(0, 0);
		send_draw(8100, 8100, 8300, 8100, 8100, 8300, 32'h12345678);
		send_read(IMG_WIDTH - 1, IMG_HEIGHT - 1);
		// extreme coordinates: one draw whose box spans the full image, then the same corners back facing
		send_draw(-32768, -32768, 32767, -32768, -32768, 32767, 32'hFFFFFFFF);
		send_read(0, IMG_HEIGHT - 1);
		send_read(IMG_WIDTH - 1, 0);
		send_read(300, 200);
		send_draw(-32768, -32768, -32768, 32767, 32767, -32768, 32'h00000000);
		send_draw(1600, 1600, 1760, 1600, 1600, 1760, 32'h00000000);
		send_read(101, 101);
		hold_until_empty();

		// random mix of draws and reads
		for (i = 0; i < 1080; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 25;
					default: gap_pct = 50;
				endcase
			end
			if (i == 980)
				calm = 1'b1;
			if (i % 300 == 299)
				hold_until_empty();
			if ($urandom_range(0, 1) == 0) begin
				random_draw();
			end else if ($urandom_range(0, 9) < 6) begin
				col = recent_x + $urandom_range(0, recent_reach);
				row = recent_y + $urandom_range(0, recent_reach);
				send_read((col > IMG_WIDTH - 1) ? IMG_WIDTH - 1 : col,
					(row > IMG_HEIGHT - 1) ? IMG_HEIGHT - 1 : row);
			end else begin
				send_read($urandom_range(0, 511), $urandom_range(0, 511));
			end
		end

		hold_until_empty();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("triangle_rasterizer_unit test passed");
		else
			$display("triangle_rasterizer_unit test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/trz_pkg.sv
rtl/core/trz_ram.sv
rtl/core/trz_edge_unit.sv
rtl/core/triangle_rasterizer_unit.sv
tb/trz_raster_checker.sv
tb/tb_top.sv
